FILE: sv/array_index_home_mapper_macros.svh
// assertion macros for the array index home mapper checker
// no dependencies; taken in by the checker file only
`ifndef ARRAY_INDEX_HOME_MAPPER_MACROS_SVH
`define ARRAY_INDEX_HOME_MAPPER_MACROS_SVH

// rising-edge check, switched off while reset is held
`define AIHM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// rising-edge check that also runs while reset is held
`define AIHM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/aihm_pkg.sv
// shared constants, codes and types of the array index home mapper
// no dependencies; used by the interfaces and every module
package aihm_pkg;

  // sizing
  localparam int unsigned MAX_DIMS   = 6;
  localparam int unsigned NUM_SLOTS  = 6;
  localparam int unsigned SLOT_W     = $clog2(NUM_SLOTS);
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned PROC_BITS  = 16;
  localparam int unsigned DIM_W      = 3;
  localparam int unsigned NB_W       = 3;
  localparam int unsigned FLAT_W     = 31;
  localparam int unsigned DVS_W      = FLAT_W + 1;
  localparam int unsigned PROD_W     = FLAT_W + COORD_BITS;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIV_STEPS  = FLAT_W;

  localparam logic [FLAT_W-1:0] FLAT_MAX = '1;

  // mapping modes; the spare code behaves as round robin
  localparam logic [MODE_W-1:0] MODE_BALANCED    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FAST        = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIM_ERR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PROCS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_C  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_D  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_E  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_F  = 3'd7;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef coord_t [NUM_SLOTS-1:0] coord_vec_t;

  // configuration and the values derived from it
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [PROC_BITS-1:0] procs;     // zero already replaced by one
    logic [NB_W-1:0]      nb;        // bound count
    coord_vec_t           extents;
    logic [FLAT_W-1:0]    total;
    logic                 total_ovf;
    logic [FLAT_W-1:0]    blk;
    logic [DVS_W-1:0]     blk_inc;
    logic [PROC_BITS-1:0] rem;
    logic [DVS_W-1:0]     first;
    logic                 busy;
  } cfg_t;

  // item in the flattening stages
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DIM_W-1:0]    dims;
    logic [FLAT_W-1:0]   flat;
    coord_vec_t          coords;
  } flat_item_t;

  // item in the divider stages
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 use_rem;
    logic [PROC_BITS-1:0] offset;
    logic [DVS_W-1:0]     divisor;
    logic [FLAT_W-1:0]    dvd;       // dividend shifting out, quotient shifting in
    logic [DVS_W-1:0]     part;      // partial remainder
  } div_item_t;

  typedef struct packed {
    logic [FLAT_W-1:0]   home;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

FILE: sv/aihm_if.sv
// channel interfaces of the array index home mapper: index in, result out, register write
// depends on aihm_pkg
interface aihm_in_if;
  logic                             valid;
  logic                             ready;
  logic [aihm_pkg::DIM_W-1:0]       dim_count;
  logic [aihm_pkg::COORD_BITS-1:0]  coord_a;
  logic [aihm_pkg::COORD_BITS-1:0]  coord_b;
  logic [aihm_pkg::COORD_BITS-1:0]  coord_c;
  logic [aihm_pkg::COORD_BITS-1:0]  coord_d;
  logic [aihm_pkg::COORD_BITS-1:0]  coord_e;
  logic [aihm_pkg::COORD_BITS-1:0]  coord_f;

  modport source (
    output valid, dim_count, coord_a, coord_b, coord_c, coord_d, coord_e, coord_f,
    input  ready
  );
  modport sink (
    input  valid, dim_count, coord_a, coord_b, coord_c, coord_d, coord_e, coord_f,
    output ready
  );
endinterface

interface aihm_out_if;
  logic                           valid;
  logic                           ready;
  logic [aihm_pkg::FLAT_W-1:0]    home_proc;
  logic [aihm_pkg::STATUS_W-1:0]  status;

  modport source (output valid, home_proc, status, input ready);
  modport sink (input valid, home_proc, status, output ready);
endinterface

interface aihm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [aihm_pkg::CFG_IDX_W-1:0]   index;
  logic [aihm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/aihm_cfg.sv
// register file plus a sequencer that derives element total, block size and split point
// depends on aihm_pkg
module aihm_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [aihm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [aihm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output aihm_pkg::cfg_t                   cfg_o
);

  localparam int unsigned CNT_W = $clog2(aihm_pkg::DIV_STEPS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                         state_q;
  logic [aihm_pkg::MODE_W-1:0]        mode_q;
  logic [aihm_pkg::PROC_BITS-1:0]     procs_q;
  aihm_pkg::coord_vec_t               ext_q;
  logic [aihm_pkg::SLOT_W-1:0]        ext_sel;
  logic [aihm_pkg::NB_W-1:0]          nb;
  logic                               run;
  logic [aihm_pkg::PROC_BITS-1:0]     procs_eff;
  logic [aihm_pkg::NB_W-1:0]          dix_q;
  logic [aihm_pkg::FLAT_W-1:0]        total_q;
  logic                               ovf_q;
  logic [aihm_pkg::PROD_W-1:0]        mul;
  logic [aihm_pkg::FLAT_W-1:0]        quo_q;
  logic [aihm_pkg::PROC_BITS-1:0]     part_q;
  logic [CNT_W-1:0]                   cnt_q;
  logic [aihm_pkg::PROC_BITS:0]       trial;
  logic [aihm_pkg::PROC_BITS:0]       diff;
  logic                               fits;
  logic [aihm_pkg::FLAT_W-1:0]        blk_c;
  logic [aihm_pkg::DVS_W-1:0]         blk_inc_c;
  logic [aihm_pkg::PROC_BITS+aihm_pkg::DVS_W-1:0] first_c;
  logic [aihm_pkg::FLAT_W-1:0]        blk_q;
  logic [aihm_pkg::DVS_W-1:0]         blk_inc_q;
  logic [aihm_pkg::PROC_BITS-1:0]     rem_q;
  logic [aihm_pkg::DVS_W-1:0]         first_q;

  // register writes
  assign ext_sel = aihm_pkg::SLOT_W'(cfg_index_i - aihm_pkg::REG_EXTENT_A);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= aihm_pkg::MODE_BALANCED;
      procs_q <= aihm_pkg::PROC_BITS'(1);
      ext_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        aihm_pkg::REG_MAP_MODE:  mode_q  <= cfg_data_i[aihm_pkg::MODE_W-1:0];
        aihm_pkg::REG_NUM_PROCS: procs_q <= cfg_data_i[aihm_pkg::PROC_BITS-1:0];
        aihm_pkg::REG_EXTENT_A, aihm_pkg::REG_EXTENT_B, aihm_pkg::REG_EXTENT_C,
        aihm_pkg::REG_EXTENT_D, aihm_pkg::REG_EXTENT_E, aihm_pkg::REG_EXTENT_F: begin
          ext_q[ext_sel] <= cfg_data_i[aihm_pkg::COORD_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  // bound count: leading run of nonzero extents
  always_comb begin
    run = 1'b1;
    nb  = '0;
    for (int k = 0; k < aihm_pkg::MAX_DIMS; k++) begin
      if (run && ext_q[k] != '0) begin
        nb = aihm_pkg::NB_W'(k + 1);
      end else begin
        run = 1'b0;
      end
    end
  end

  assign procs_eff = (procs_q == '0) ? aihm_pkg::PROC_BITS'(1) : procs_q;

  // one extent product per cycle
  assign mul = aihm_pkg::PROD_W'(total_q)
             * aihm_pkg::PROD_W'(ext_q[dix_q[aihm_pkg::SLOT_W-1:0]]);

  // one quotient bit per cycle of total / procs
  assign trial = {part_q, quo_q[aihm_pkg::FLAT_W-1]};
  assign fits  = trial >= (aihm_pkg::PROC_BITS + 1)'(procs_eff);
  assign diff  = trial - (aihm_pkg::PROC_BITS + 1)'(procs_eff);

  // block size, its increment and the split point
  assign blk_c     = (quo_q == '0) ? aihm_pkg::FLAT_W'(1) : quo_q;
  assign blk_inc_c = aihm_pkg::DVS_W'(blk_c) + aihm_pkg::DVS_W'(1);
  assign first_c   = part_q * blk_inc_c;

  // derivation sequencer, restarted by every register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dix_q     <= '0;
      total_q   <= '0;
      ovf_q     <= 1'b0;
      quo_q     <= '0;
      part_q    <= '0;
      cnt_q     <= '0;
      blk_q     <= aihm_pkg::FLAT_W'(1);
      blk_inc_q <= aihm_pkg::DVS_W'(2);
      rem_q     <= '0;
      first_q   <= '0;
    end else if (cfg_valid_i) begin
      state_q <= S_MUL;
      dix_q   <= '0;
      total_q <= aihm_pkg::FLAT_W'(1);
      ovf_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: ;
        S_MUL: begin
          if (dix_q < nb && !ovf_q) begin
            if (mul > aihm_pkg::PROD_W'(aihm_pkg::FLAT_MAX)) begin
              ovf_q <= 1'b1;
            end else begin
              total_q <= mul[aihm_pkg::FLAT_W-1:0];
            end
            dix_q <= dix_q + aihm_pkg::NB_W'(1);
          end else begin
            total_q <= (nb == '0) ? '0 : total_q;
            quo_q   <= (nb == '0) ? '0 : total_q;
            part_q  <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          part_q <= fits ? diff[aihm_pkg::PROC_BITS-1:0] : trial[aihm_pkg::PROC_BITS-1:0];
          quo_q  <= {quo_q[aihm_pkg::FLAT_W-2:0], fits};
          cnt_q  <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(aihm_pkg::DIV_STEPS - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          blk_q     <= blk_c;
          blk_inc_q <= blk_inc_c;
          rem_q     <= part_q;
          first_q   <= first_c[aihm_pkg::DVS_W-1:0];
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cfg_o.mode      = mode_q;
    cfg_o.procs     = procs_eff;
    cfg_o.nb        = nb;
    cfg_o.extents   = ext_q;
    cfg_o.total     = total_q;
    cfg_o.total_ovf = ovf_q;
    cfg_o.blk       = blk_q;
    cfg_o.blk_inc   = blk_inc_q;
    cfg_o.rem       = rem_q;
    cfg_o.first     = first_q;
    cfg_o.busy      = (state_q != S_IDLE);
  end

endmodule

FILE: sv/aihm_flatten.sv
// entry stage with dimension check, then one multiply-add stage per extra coordinate
// depends on aihm_pkg
module aihm_flatten (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic [aihm_pkg::DIM_W-1:0]    dim_count_i,
  input  aihm_pkg::coord_vec_t          coords_i,
  input  aihm_pkg::cfg_t                cfg_i,
  output logic                          valid_o,
  output aihm_pkg::flat_item_t          item_o
);

  localparam int unsigned LAST = aihm_pkg::MAX_DIMS - 1;

  aihm_pkg::flat_item_t          stg_q [aihm_pkg::MAX_DIMS];
  aihm_pkg::flat_item_t          stg_d [aihm_pkg::MAX_DIMS];
  logic [aihm_pkg::MAX_DIMS-1:0] vld_q;
  logic [aihm_pkg::PROD_W-1:0]   prod  [aihm_pkg::MAX_DIMS];

  // stage inputs: dimension check at entry, one row-major step per later stage
  always_comb begin
    stg_d[0].status = aihm_pkg::ST_OK;
    if (dim_count_i != aihm_pkg::DIM_W'(1)
        && (cfg_i.nb == '0 || dim_count_i != cfg_i.nb)) begin
      stg_d[0].status = aihm_pkg::ST_DIM_ERR;
    end
    stg_d[0].dims   = dim_count_i;
    stg_d[0].flat   = aihm_pkg::FLAT_W'(coords_i[0]);
    stg_d[0].coords = coords_i;
    prod[0]         = '0;
    for (int k = 1; k < aihm_pkg::MAX_DIMS; k++) begin
      prod[k]  = aihm_pkg::PROD_W'(stg_q[k-1].flat) * aihm_pkg::PROD_W'(cfg_i.extents[k])
               + aihm_pkg::PROD_W'(stg_q[k-1].coords[k]);
      stg_d[k] = stg_q[k-1];
      if (stg_q[k-1].status == aihm_pkg::ST_OK
          && stg_q[k-1].dims != aihm_pkg::DIM_W'(1)
          && aihm_pkg::NB_W'(k) < cfg_i.nb) begin
        if (prod[k] > aihm_pkg::PROD_W'(aihm_pkg::FLAT_MAX)) begin
          stg_d[k].status = aihm_pkg::ST_OVERFLOW;
        end else begin
          stg_d[k].flat = prod[k][aihm_pkg::FLAT_W-1:0];
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < aihm_pkg::MAX_DIMS; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < aihm_pkg::MAX_DIMS; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign valid_o = vld_q[LAST];
  assign item_o  = stg_q[LAST];

endmodule

FILE: sv/aihm_div.sv
// mode select stage, then a restoring divider with one quotient bit per stage
// depends on aihm_pkg
module aihm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  aihm_pkg::flat_item_t  item_i,
  input  aihm_pkg::cfg_t        cfg_i,
  output logic                  valid_o,
  output aihm_pkg::result_t     res_o
);

  localparam int unsigned NSTG = aihm_pkg::DIV_STEPS + 1;

  aihm_pkg::div_item_t        dq_q [NSTG];
  aihm_pkg::div_item_t        dq_d [NSTG];
  logic [NSTG-1:0]            vld_q;
  logic [aihm_pkg::DVS_W:0]   trial [NSTG];
  logic [aihm_pkg::DVS_W:0]   diff  [NSTG];
  logic                       fits  [NSTG];
  logic                       block_mode;
  logic                       lt_first;
  logic                       lt_total;
  aihm_pkg::div_item_t        last;

  // select dividend, divisor and result kind for the mode
  assign block_mode = (cfg_i.mode == aihm_pkg::MODE_BALANCED)
                   || (cfg_i.mode == aihm_pkg::MODE_FAST);
  assign lt_first   = aihm_pkg::DVS_W'(item_i.flat) < cfg_i.first;
  assign lt_total   = item_i.flat < cfg_i.total;

  always_comb begin
    dq_d[0].status  = item_i.status;
    if (item_i.status == aihm_pkg::ST_OK && block_mode && cfg_i.nb != '0
        && cfg_i.total_ovf) begin
      dq_d[0].status = aihm_pkg::ST_OVERFLOW;
    end
    dq_d[0].use_rem = 1'b1;
    dq_d[0].offset  = '0;
    dq_d[0].divisor = aihm_pkg::DVS_W'(cfg_i.procs);
    dq_d[0].dvd     = item_i.flat;
    dq_d[0].part    = '0;
    unique case (cfg_i.mode)
      aihm_pkg::MODE_BALANCED: begin
        if (lt_first) begin
          dq_d[0].use_rem = 1'b0;
          dq_d[0].divisor = cfg_i.blk_inc;
        end else if (lt_total) begin
          dq_d[0].use_rem = 1'b0;
          dq_d[0].divisor = aihm_pkg::DVS_W'(cfg_i.blk);
          dq_d[0].dvd     = item_i.flat - cfg_i.first[aihm_pkg::FLAT_W-1:0];
          dq_d[0].offset  = cfg_i.rem;
        end
      end
      aihm_pkg::MODE_FAST: begin
        dq_d[0].use_rem = 1'b0;
        dq_d[0].divisor = aihm_pkg::DVS_W'(cfg_i.blk);
      end
      default: ;
    endcase

    // divider stages
    trial[0] = '0;
    diff[0]  = '0;
    fits[0]  = 1'b0;
    for (int k = 1; k < NSTG; k++) begin
      trial[k] = {dq_q[k-1].part, dq_q[k-1].dvd[aihm_pkg::FLAT_W-1]};
      diff[k]  = trial[k] - {1'b0, dq_q[k-1].divisor};
      fits[k]  = trial[k] >= {1'b0, dq_q[k-1].divisor};
      dq_d[k]      = dq_q[k-1];
      dq_d[k].part = fits[k] ? diff[k][aihm_pkg::DVS_W-1:0] : trial[k][aihm_pkg::DVS_W-1:0];
      dq_d[k].dvd  = {dq_q[k-1].dvd[aihm_pkg::FLAT_W-2:0], fits[k]};
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NSTG; k++) begin
        dq_q[k] <= dq_d[k];
      end
    end
  end

  // quotient plus offset, or remainder; zero when flagged
  assign last    = dq_q[NSTG-1];
  assign valid_o = vld_q[NSTG-1];

  always_comb begin
    res_o.status = last.status;
    if (last.status != aihm_pkg::ST_OK) begin
      res_o.home = '0;
    end else if (last.use_rem) begin
      res_o.home = last.part[aihm_pkg::FLAT_W-1:0];
    end else begin
      res_o.home = last.dvd + aihm_pkg::FLAT_W'(last.offset);
    end
  end

endmodule

FILE: sv/array_index_home_mapper.sv
// Array index home mapper: maps a multi-dimensional index to its home processor.
// in_ch carries dim_count and six coordinates; out_ch returns home_proc and status
// (ok, dimension mismatch or no bounds, flat index or element total over 31 bits).
// cfg_ch writes map_mode, num_procs and extent_a..extent_f; it is always ready.
// After each register write the derived block values are rebuilt (extent products,
// one quotient bit per cycle, split point); in_ch.ready stays low meanwhile.
// Path of a result: entry stage, five multiply-add stages, a mode select stage,
// 31 divider stages, output register. Throughput: one transaction per cycle, set
// by the bit-per-stage divider pipeline, while neither a full skid register nor
// a rebuild holds in_ch.ready low.
// The output register is backed by a skid register; the pipeline freezes only once
// both are full, so a stalled receiver loses and repeats nothing.
// Reset clears all valid bits and loads the register reset values
// (balanced block, one processor, no bounds).
// depends on aihm_pkg, aihm_if, aihm_cfg, aihm_flatten, aihm_div
module array_index_home_mapper (
  input  logic              clk_i,
  input  logic              rst_ni,
  aihm_in_if.sink           in_ch,
  aihm_out_if.source        out_ch,
  aihm_cfg_if.sink          cfg_ch
);

  aihm_pkg::cfg_t        cfg;
  aihm_pkg::coord_vec_t  coords;
  aihm_pkg::flat_item_t  flat_item;
  aihm_pkg::result_t     res;
  aihm_pkg::result_t     out_q;
  aihm_pkg::result_t     skid_q;
  logic                  flat_valid;
  logic                  res_valid;
  logic                  en;
  logic                  accept;
  logic                  arrive;
  logic                  out_valid_q;
  logic                  out_valid_d;
  logic                  skid_valid_q;
  logic                  skid_valid_d;
  logic                  load_out;
  logic                  load_skid;
  logic                  out_from_skid;

  // configuration
  assign cfg_ch.ready = 1'b1;

  aihm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_index_i (cfg_ch.index),
    .cfg_data_i  (cfg_ch.data),
    .cfg_o       (cfg)
  );

  // pipeline advances unless the skid register holds a result
  assign en          = !skid_valid_q;
  assign in_ch.ready = en && !cfg.busy;
  assign accept      = in_ch.valid && in_ch.ready;

  assign coords[0] = in_ch.coord_a;
  assign coords[1] = in_ch.coord_b;
  assign coords[2] = in_ch.coord_c;
  assign coords[3] = in_ch.coord_d;
  assign coords[4] = in_ch.coord_e;
  assign coords[5] = in_ch.coord_f;

  aihm_flatten u_flatten (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (accept),
    .dim_count_i (in_ch.dim_count),
    .coords_i    (coords),
    .cfg_i       (cfg),
    .valid_o     (flat_valid),
    .item_o      (flat_item)
  );

  aihm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (flat_valid),
    .item_i  (flat_item),
    .cfg_i   (cfg),
    .valid_o (res_valid),
    .res_o   (res)
  );

  // output register with skid
  assign arrive = en && res_valid;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (arrive) begin
      if (out_valid_q && !out_ch.ready) begin
        skid_valid_d = 1'b1;
        load_skid    = 1'b1;
      end else begin
        out_valid_d = 1'b1;
        load_out    = 1'b1;
      end
    end else if (skid_valid_q && out_ch.ready) begin
      out_valid_d   = 1'b1;
      skid_valid_d  = 1'b0;
      out_from_skid = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end else if (out_from_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.home_proc = out_q.home;
  assign out_ch.status    = out_q.status;

endmodule

FILE: sv/aihm_checker.sv
// port-level checks of the array index home mapper, bound to the top level
// depends on array_index_home_mapper_macros.svh and aihm_pkg
`include "array_index_home_mapper_macros.svh"

module aihm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [aihm_pkg::FLAT_W-1:0]    home_proc_i,
  input logic [aihm_pkg::STATUS_W-1:0]  status_i,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_i
);

  localparam int unsigned OUTS_W = 7;

  logic [OUTS_W-1:0] outstanding_q;
  logic              in_take;
  logic              out_take;

  // transactions taken but not yet delivered
  assign in_take  = in_valid_i && in_ready_i;
  assign out_take = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + OUTS_W'(in_take) - OUTS_W'(out_take);
    end
  end

  // a flagged result never carries a processor number
  `AIHM_ASSERT(a_flag_home_zero, clk_i, rst_ni, out_valid_i && status_i != aihm_pkg::ST_OK |-> home_proc_i == '0, "flagged result with nonzero home")

  // no result without an earlier input transaction
  `AIHM_ASSERT(a_no_invented, clk_i, rst_ni, out_valid_i |-> outstanding_q != '0, "result without pending input")

  // a stalled result stays put
  `AIHM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(home_proc_i) && $stable(status_i), "stalled result changed")

  // a register write holds off input while derived values are rebuilt
  `AIHM_ASSERT(a_cfg_blocks_in, clk_i, rst_ni, cfg_valid_i && cfg_ready_i |=> !in_ready_i, "input taken during rebuild")

  // nothing is offered while reset is held
  `AIHM_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i, "result offered in reset")

endmodule

bind array_index_home_mapper aihm_checker u_aihm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .home_proc_i (out_ch.home_proc),
  .status_i    (out_ch.status),
  .cfg_valid_i (cfg_ch.valid),
  .cfg_ready_i (cfg_ch.ready)
);

FILE: sim/array_index_home_mapper_test.sv
// self-checking bench for the array index home mapper: directed layouts, then random ones
// depends on aihm_pkg, aihm_if and array_index_home_mapper; predicts every home processor itself
module array_index_home_mapper_test;

  localparam logic [aihm_pkg::MODE_W-1:0] MODE_SPARE  = 2'd3;
  localparam logic [63:0]                 FLAT_LIMIT  = 64'h7FFF_FFFF;
  localparam int unsigned                 NUM_PHASES  = 12;
  localparam int unsigned                 PHASE_ITEMS = 105;

  typedef struct packed {
    logic [aihm_pkg::DIM_W-1:0] dims;
    aihm_pkg::coord_vec_t       coords;
  } index_t;

  logic clk;
  logic rst_n;

  aihm_in_if  in_ch ();
  aihm_out_if out_ch ();
  aihm_cfg_if cfg_ch ();

  array_index_home_mapper dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the register file
  logic [aihm_pkg::MODE_W-1:0]    mode_setting;
  logic [aihm_pkg::PROC_BITS-1:0] procs_setting;
  aihm_pkg::coord_vec_t           extent_setting;

  aihm_pkg::result_t expected_homes [$];
  aihm_pkg::result_t oldest_home;
  int                errors;
  int                in_idle_pct;
  int                out_idle_pct;
  int                receiver_hold_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(12 * 500000);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls, or a long counted hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        receiver_hold_cycles--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // result checker: each transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_homes.size() == 0) begin
        $display("%0t unexpected result: expected none, actual home_proc %0d status %0d",
                 $time, out_ch.home_proc, out_ch.status);
        errors++;
      end else begin
        oldest_home = expected_homes.pop_front();
        if (out_ch.home_proc !== oldest_home.home) begin
          $display("%0t home_proc mismatch: expected %0d actual %0d",
                   $time, oldest_home.home, out_ch.home_proc);
          errors++;
        end
        if (out_ch.status !== oldest_home.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, oldest_home.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  // length of the leading run of nonzero bounds
  function automatic int bound_count();
    int  nb;
    int  d;
    bit  run;
    nb  = 0;
    run = 1'b1;
    for (d = 0; d < aihm_pkg::MAX_DIMS; d++) begin
      if (run && extent_setting[d] != '0) nb++;
      else run = 1'b0;
    end
    return nb;
  endfunction

  // home processor and status of one index under the current registers
  function automatic aihm_pkg::result_t home_of(input index_t it);
    logic [63:0]                   flat;
    logic [63:0]                   total;
    logic [63:0]                   blk;
    logic [63:0]                   rem;
    logic [63:0]                   first;
    logic [63:0]                   home;
    logic [63:0]                   procs;
    logic [aihm_pkg::STATUS_W-1:0] st;
    logic                          block_mode;
    int                            nb;
    int                            d;
    aihm_pkg::result_t             res;
    nb    = bound_count();
    procs = (procs_setting == '0) ? 64'd1 : {48'd0, procs_setting};
    flat  = {48'd0, it.coords[0]};
    st    = aihm_pkg::ST_OK;
    home  = '0;
    // row-major flattening over the bound coordinates
    if (it.dims != 3'd1) begin
      if (nb == 0 || it.dims != nb) begin
        st = aihm_pkg::ST_DIM_ERR;
      end else begin
        for (d = 1; d < nb && st == aihm_pkg::ST_OK; d++) begin
          flat = flat * extent_setting[d] + it.coords[d];
          if (flat > FLAT_LIMIT) st = aihm_pkg::ST_OVERFLOW;
        end
      end
    end
    if (st == aihm_pkg::ST_OK && flat > FLAT_LIMIT) st = aihm_pkg::ST_OVERFLOW;
    // element total, block modes only
    block_mode = (mode_setting == aihm_pkg::MODE_BALANCED)
              || (mode_setting == aihm_pkg::MODE_FAST);
    total = '0;
    if (st == aihm_pkg::ST_OK && block_mode && nb > 0) begin
      total = 64'd1;
      for (d = 0; d < nb && st == aihm_pkg::ST_OK; d++) begin
        total = total * extent_setting[d];
        if (total > FLAT_LIMIT) st = aihm_pkg::ST_OVERFLOW;
      end
    end
    if (st == aihm_pkg::ST_OK) begin
      blk = total / procs;
      if (blk == '0) blk = 64'd1;
      rem   = total % procs;
      first = rem * (blk + 1);
      case (mode_setting)
        aihm_pkg::MODE_BALANCED: begin
          if (flat < first) home = flat / (blk + 1);
          else if (flat < total) home = (flat - first) / blk + rem;
          else home = flat % procs;
        end
        aihm_pkg::MODE_FAST: home = flat / blk;
        default:             home = flat % procs;
      endcase
    end
    res.home   = (st == aihm_pkg::ST_OK) ? home[aihm_pkg::FLAT_W-1:0] : '0;
    res.status = st;
    return res;
  endfunction

  function automatic aihm_pkg::coord_vec_t coords_of(
      input aihm_pkg::coord_t a, input aihm_pkg::coord_t b, input aihm_pkg::coord_t c,
      input aihm_pkg::coord_t d, input aihm_pkg::coord_t e, input aihm_pkg::coord_t f);
    return {f, e, d, c, b, a};
  endfunction

  // random index: mostly well formed for the current bounds, the rest noise
  function automatic index_t random_index();
    index_t it;
    int     nb;
    int     d;
    int     r;
    nb = bound_count();
    r  = $urandom_range(0, 99);
    for (d = 0; d < aihm_pkg::MAX_DIMS; d++)
      it.coords[d] = aihm_pkg::coord_t'($urandom_range(0, 65535));
    it.dims = (nb == 0) ? 3'd1 : nb[aihm_pkg::DIM_W-1:0];
    if (r < 90 && !(r >= 70 && r < 80)) begin
      for (d = 0; d < nb; d++)
        it.coords[d] = aihm_pkg::coord_t'($urandom_range(0, extent_setting[d] - 1));
    end
    if (r >= 70 && r < 80) begin
      // plain flat index
      it.dims = 3'd1;
      if (r < 75) it.coords[0] = aihm_pkg::coord_t'($urandom_range(0, 255));
    end else if (r >= 80 && r < 90) begin
      // one coordinate drawn over its full range, often past its bound
      it.coords[$urandom_range(0, (nb == 0) ? 0 : nb - 1)] =
        aihm_pkg::coord_t'($urandom_range(0, 65535));
    end else if (r >= 90) begin
      it.dims = aihm_pkg::DIM_W'($urandom_range(0, 7));
    end
    return it;
  endfunction

  task automatic wait_drained();
    while (expected_homes.size() != 0) @(posedge clk);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // one register write transaction
  task automatic write_register(input logic [aihm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [aihm_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      aihm_pkg::REG_MAP_MODE:  mode_setting = value[aihm_pkg::MODE_W-1:0];
      aihm_pkg::REG_NUM_PROCS: procs_setting = value[aihm_pkg::PROC_BITS-1:0];
      default: begin
        extent_setting[idx - aihm_pkg::REG_EXTENT_A] = value[aihm_pkg::COORD_BITS-1:0];
      end
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // full register set, written only once the pipeline is empty
  task automatic configure(input logic [aihm_pkg::MODE_W-1:0] mode,
                           input logic [aihm_pkg::PROC_BITS-1:0] procs,
                           input aihm_pkg::coord_vec_t bounds);
    int d;
    wait_drained();
    write_register(aihm_pkg::REG_MAP_MODE, aihm_pkg::CFG_DATA_W'(mode));
    write_register(aihm_pkg::REG_NUM_PROCS, procs);
    for (d = 0; d < aihm_pkg::MAX_DIMS; d++)
      write_register(aihm_pkg::REG_EXTENT_A + aihm_pkg::CFG_IDX_W'(d), bounds[d]);
  endtask

  // one index transaction, with random sender gaps in front
  task automatic offer_index(input index_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.dim_count = it.dims;
    in_ch.coord_a   = it.coords[0];
    in_ch.coord_b   = it.coords[1];
    in_ch.coord_c   = it.coords[2];
    in_ch.coord_d   = it.coords[3];
    in_ch.coord_e   = it.coords[4];
    in_ch.coord_f   = it.coords[5];
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_homes.push_back(home_of(it));
  endtask

  task automatic offer_coords(input int dims, input aihm_pkg::coord_vec_t coords);
    index_t it;
    it.dims   = aihm_pkg::DIM_W'(dims);
    it.coords = coords;
    offer_index(it);
  endtask

  task automatic offer_random(input int count);
    int i;
    for (i = 0; i < count; i++) offer_index(random_index());
    drop_valid();
  endtask

  // random register set; dimension-dependent bounds keep most totals in range
  task automatic pick_layout();
    aihm_pkg::coord_vec_t           bounds;
    logic [aihm_pkg::MODE_W-1:0]    mode;
    logic [aihm_pkg::PROC_BITS-1:0] procs;
    int                             nb;
    int                             d;
    int                             r;
    r = $urandom_range(0, 9);
    if (r < 3) mode = aihm_pkg::MODE_BALANCED;
    else if (r < 6) mode = aihm_pkg::MODE_FAST;
    else if (r < 9) mode = aihm_pkg::MODE_ROUND_ROBIN;
    else mode = MODE_SPARE;
    case ($urandom_range(0, 7))
      0:       procs = '0;
      1:       procs = 16'd1;
      2:       procs = 16'hFFFF;
      3, 4:    procs = aihm_pkg::PROC_BITS'($urandom_range(2, 16));
      default: procs = aihm_pkg::PROC_BITS'($urandom_range(0, 65535));
    endcase
    nb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    for (d = 0; d < aihm_pkg::MAX_DIMS; d++) begin
      if (d < nb) begin
        case (nb)
          1:       bounds[d] = aihm_pkg::coord_t'($urandom_range(1, 65535));
          2:       bounds[d] = aihm_pkg::coord_t'($urandom_range(1, 46000));
          3:       bounds[d] = aihm_pkg::coord_t'($urandom_range(1, 1200));
          4:       bounds[d] = aihm_pkg::coord_t'($urandom_range(1, 200));
          5:       bounds[d] = aihm_pkg::coord_t'($urandom_range(1, 70));
          default: bounds[d] = aihm_pkg::coord_t'($urandom_range(1, 35));
        endcase
        if ($urandom_range(0, 11) == 0) bounds[d] = 16'hFFFF;
      end else if (d == nb) begin
        bounds[d] = '0;
      end else begin
        // past the end of the bound list, so ignored
        bounds[d] = aihm_pkg::coord_t'($urandom_range(0, 65535));
      end
    end
    configure(mode, procs, bounds);
  endtask

  // reset registers: balanced, one processor, no bounds
  task automatic test_reset_values();
    offer_coords(1, coords_of(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(1, coords_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    offer_coords(0, coords_of(16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(7, coords_of(16'd3, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5));
    offer_coords(2, coords_of(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0));
    drop_valid();
  endtask

  // balanced split with a remainder, and fast block with ignored trailing bounds
  task automatic test_directed_layouts();
    configure(aihm_pkg::MODE_BALANCED, 16'd3,
              coords_of(16'd5, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(2, coords_of(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(2, coords_of(16'd3, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(2, coords_of(16'd3, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(2, coords_of(16'd4, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(1, coords_of(16'd25, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(2, coords_of(16'd9, 16'd9, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(3, coords_of(16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0));
    drop_valid();
    configure(aihm_pkg::MODE_FAST, 16'd4,
              coords_of(16'd8, 16'd8, 16'd2, 16'd0, 16'd7, 16'd9));
    offer_coords(3, coords_of(16'd7, 16'd7, 16'd1, 16'd0, 16'd0, 16'd0));
    offer_coords(3, coords_of(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    drop_valid();
  endtask

  // total and flat index overflow, zero processor count, spare mode code
  task automatic test_overflow_and_spare_codes();
    aihm_pkg::coord_vec_t full;
    full = '1;
    configure(aihm_pkg::MODE_FAST, 16'd0, full);
    offer_coords(6, coords_of(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(1, coords_of(16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    drop_valid();
    configure(MODE_SPARE, 16'd0, full);
    offer_coords(1, full);
    offer_coords(6, full);
    offer_coords(6, coords_of(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_coords(5, coords_of(16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd0));
    drop_valid();
  endtask

  // random layouts in turn, under each idling pattern
  task automatic test_random_layouts();
    int p;
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_PHASES / 3) begin
        in_idle_pct  = 34;
        out_idle_pct = 49;
      end else if (p < 2 * NUM_PHASES / 3) begin
        in_idle_pct  = 49;
        out_idle_pct = 34;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      pick_layout();
      offer_random(PHASE_ITEMS);
    end
  endtask

  // long receiver hold-off fills the pipeline; then the sender waits for a full drain
  task automatic test_output_backpressure();
    pick_layout();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    @(negedge clk);
    receiver_hold_cycles = 300;
    offer_random(60);
    wait_drained();
    out_idle_pct = 30;
    offer_random(40);
  endtask

  // stimulus
  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.dim_count      = '0;
    in_ch.coord_a        = '0;
    in_ch.coord_b        = '0;
    in_ch.coord_c        = '0;
    in_ch.coord_d        = '0;
    in_ch.coord_e        = '0;
    in_ch.coord_f        = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    mode_setting         = aihm_pkg::MODE_BALANCED;
    procs_setting        = 16'd1;
    extent_setting       = '0;
    errors               = 0;
    in_idle_pct          = 34;
    out_idle_pct         = 49;
    receiver_hold_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_directed_layouts();
    test_overflow_and_spare_codes();
    test_random_layouts();
    test_output_backpressure();

    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
